/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the read-register master.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the house clock and reset names.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/mrm_pkg.sv */
// Package of the Modbus RTU read-register master: item types, codes, CRC step.
// No dependencies.
package mrm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_RX    = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_READING = 1'b1
  } cmd_kind_e;

  typedef enum logic {
    TX_IDLE = 1'b0,
    TX_SEND = 1'b1
  } tx_state_e;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd1;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h12;
  localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd1000;
  localparam logic [7:0]  FUNC_READ_HOLDING  = 8'h03;
  localparam logic [7:0]  QUANTITY_ONE       = 8'h01;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_POLY           = 16'hA001;

  // response byte positions
  localparam logic [2:0] RX_VALUE_HI = 3'd3;
  localparam logic [2:0] RX_VALUE_LO = 3'd4;
  localparam logic [2:0] RX_CRC_LO   = 3'd5;
  localparam logic [2:0] RX_CRC_HI   = 3'd6;

  // request byte positions
  localparam logic [2:0] TX_FUNC   = 3'd1;
  localparam logic [2:0] TX_REG_HI = 3'd2;
  localparam logic [2:0] TX_REG_LO = 3'd3;
  localparam logic [2:0] TX_QTY_HI = 3'd4;
  localparam logic [2:0] TX_QTY_LO = 3'd5;
  localparam logic [2:0] TX_CRC_LO = 3'd6;
  localparam logic [2:0] TX_CRC_HI = 3'd7;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] register_address;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_reading;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] value;
    logic [1:0]  status;
  } out_item_t;

  // command handed from front to back
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] value;
    status_e     status;
  } cmd_t;

  // CRC-16/MODBUS, one byte, reflected polynomial
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/mrm_fifo.sv */
// Small register-based command queue between front and back.
// Generic width; no package dependency.
`include "assert_macros.svh"
module mrm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_STD(a_fifo_bound, cnt_q <= CNT_W'(DEPTH), "queue count beyond depth")
  `ASSERT_STD(a_fifo_cnt_track,
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)),
    "queue count lost a push")

endmodule

/* rtl/mrm_front.sv */
// Front end: config registers, response gathering, CRC check and timeout.
// Depends on mrm_pkg; pushes commands into the queue.
`include "assert_macros.svh"
module mrm_front import mrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        push_o,
  output cmd_t        push_data_o,
  input  logic        push_ready_i
);
  logic [7:0]  dev_addr_q;
  logic [15:0] timeout_q;
  logic        waiting_q, waiting_d;
  logic [2:0]  rx_cnt_q, rx_cnt_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [15:0] value_q, value_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] tick_q, tick_d;
  logic [16:0] tick_next;
  logic        accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tick_next  = {1'b0, tick_q} + 17'd1;

  always_comb begin
    waiting_d   = waiting_q;
    rx_cnt_d    = rx_cnt_q;
    rx_crc_d    = rx_crc_q;
    value_d     = value_q;
    crc_lo_d    = crc_lo_q;
    tick_d      = tick_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (accept) begin
      case (op_e'(in_item_i.operation))
        OP_START: begin
          push_o               = 1'b1;
          push_data_o.kind     = CMD_REQUEST;
          push_data_o.dev_addr = dev_addr_q;
          push_data_o.reg_addr = in_item_i.register_address;
          waiting_d = 1'b1;
          rx_cnt_d  = '0;
          rx_crc_d  = CRC_INIT;
          value_d   = '0;
          crc_lo_d  = '0;
          tick_d    = '0;
        end
        OP_RX: begin
          if (waiting_q) begin
            if (rx_cnt_q < RX_CRC_LO) begin
              rx_crc_d = crc_byte(rx_crc_q, in_item_i.rx_byte);
              if (rx_cnt_q == RX_VALUE_HI) begin
                value_d[15:8] = in_item_i.rx_byte;
              end else if (rx_cnt_q == RX_VALUE_LO) begin
                value_d[7:0] = in_item_i.rx_byte;
              end
              rx_cnt_d = rx_cnt_q + 3'd1;
            end else if (rx_cnt_q == RX_CRC_LO) begin
              crc_lo_d = in_item_i.rx_byte;
              rx_cnt_d = RX_CRC_HI;
            end else begin
              push_o             = 1'b1;
              push_data_o.kind   = CMD_READING;
              push_data_o.value  = value_q;
              push_data_o.status = ({in_item_i.rx_byte, crc_lo_q} == rx_crc_q) ?
                                   ST_OK : ST_CRC_ERR;
              waiting_d = 1'b0;
              rx_cnt_d  = '0;
            end
          end
        end
        OP_TICK: begin
          if (waiting_q) begin
            tick_d = tick_next[15:0];
            if (tick_next >= {1'b0, timeout_q}) begin
              push_o             = 1'b1;
              push_data_o.kind   = CMD_READING;
              push_data_o.status = ST_TIMEOUT;
              waiting_d = 1'b0;
              rx_cnt_d  = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEVICE_ADDRESS_RST;
      timeout_q  <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i[7:0];
        CFG_TIMEOUT_TICKS:  timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      rx_cnt_q  <= '0;
      rx_crc_q  <= CRC_INIT;
      value_q   <= '0;
      crc_lo_q  <= '0;
      tick_q    <= '0;
    end else begin
      waiting_q <= waiting_d;
      rx_cnt_q  <= rx_cnt_d;
      rx_crc_q  <= rx_crc_d;
      value_q   <= value_d;
      crc_lo_q  <= crc_lo_d;
      tick_q    <= tick_d;
    end
  end

  `ASSERT_STD(a_front_start_arms,
    (accept && (in_item_i.operation == OP_START)) |=> (waiting_q && (rx_cnt_q == '0)),
    "start did not arm the response gatherer")

endmodule

/* rtl/mrm_back.sv */
// Back end: expands request commands into eight frame bytes, passes readings.
// Depends on mrm_pkg; owns the output register.
`include "assert_macros.svh"
module mrm_back import mrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);
  tx_state_e   state_q, state_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  reg_q, reg_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        load;
  logic [7:0]  cur_byte;

  assign load        = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    case (idx_q)
      TX_FUNC:   cur_byte = FUNC_READ_HOLDING;
      TX_REG_HI: cur_byte = 8'h00;
      TX_REG_LO: cur_byte = reg_q;
      TX_QTY_HI: cur_byte = 8'h00;
      TX_QTY_LO: cur_byte = QUANTITY_ONE;
      TX_CRC_LO: cur_byte = crc_q[7:0];
      TX_CRC_HI: cur_byte = crc_q[15:8];
      default:   cur_byte = 8'h00;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TX_IDLE: if (load && cmd_valid_i && (cmd_i.kind == CMD_REQUEST)) state_d = TX_SEND;
      TX_SEND: if (load && (idx_q == TX_CRC_HI)) state_d = TX_IDLE;
      default: state_d = TX_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    idx_d       = idx_q;
    crc_d       = crc_q;
    reg_d       = reg_q;
    if (load) begin
      out_valid_d = 1'b0;
      case (state_q)
        TX_SEND: begin
          out_valid_d   = 1'b1;
          out_d         = '0;
          out_d.tx_byte = cur_byte;
          out_d.last    = (idx_q == TX_CRC_HI);
          // CRC covers the six header bytes only; hold it for the two CRC bytes
          if (idx_q < TX_CRC_LO) begin
            crc_d = crc_byte(crc_q, cur_byte);
          end
          idx_d         = idx_q + 3'd1;
        end
        TX_IDLE: begin
          if (cmd_valid_i) begin
            cmd_pop_o   = 1'b1;
            out_valid_d = 1'b1;
            out_d       = '0;
            if (cmd_i.kind == CMD_REQUEST) begin
              out_d.tx_byte = cmd_i.dev_addr;
              crc_d         = crc_byte(CRC_INIT, cmd_i.dev_addr);
              reg_d         = cmd_i.reg_addr;
              idx_d         = TX_FUNC;
            end else begin
              out_d.is_reading = 1'b1;
              out_d.value      = cmd_i.value;
              out_d.status     = cmd_i.status;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TX_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    reg_q <= reg_d;
    out_q <= out_d;
  end

  `ASSERT_STD(a_back_send_idx, (state_q == TX_SEND) |-> (idx_q != '0),
    "frame sequencer at byte zero while sending")
  `ASSERT_STD(a_back_no_pop_busy, (state_q == TX_SEND) |-> !cmd_pop_o,
    "command taken in the middle of a frame")
  `ASSERT_STD(a_back_last_tx, (out_valid_q && out_q.last) |-> !out_q.is_reading,
    "last flag on a reading result")

endmodule

/* rtl/modbus_rtu_read_register_master.sv */
// Top level of the Modbus RTU read-register master: front, command queue, back.
// Depends on mrm_pkg, mrm_front, mrm_fifo, mrm_back.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------------
//  in      | in  | in_valid_i / in_ready_o   | in_item_i  (op, register, rx byte)
//  out     | out | out_valid_o / out_ready_i | out_item_o (tx byte or reading)
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The front takes one item per cycle while the command queue has room; byte and
// tick items settle in that cycle. A start item becomes eight output items, one
// per cycle from the back's frame sequencer unless the output stalls (its CRC
// runs one byte per cycle), and the back pops no new command until the frame's
// last byte is loaded; a reading leaves as one output item. Results pass through
// the command queue and the back's output register. Reset is asynchronous,
// active low; no clearing pass. The cfg port is always ready. An output stall
// holds the output register and, once the queue fills, stalls the input.
module modbus_rtu_read_register_master import mrm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic push, push_ready, pop, pop_valid;
  cmd_t push_cmd, pop_cmd;
  logic [$bits(cmd_t)-1:0] pop_bits;

  assign cfg_ready_o = 1'b1;

  mrm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .push_data_o  (push_cmd),
    .push_ready_i (push_ready)
  );

  mrm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_bits)
  );

  assign pop_cmd = cmd_t'(pop_bits);

  mrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the Modbus RTU read-register master.
// Depends on mrm_pkg and modbus_rtu_read_register_master; a built-in predictor
// scores every output item, first on a directed table and then on random traffic.
module testbench;
  import mrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int unsigned DIR_ROWS        = 35;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned PHASE_ITEMS     = 55;    // items that reach the block's state
  localparam int unsigned SETTLE_CYCLES   = 16;    // lets in-flight bytes and ticks settle
  localparam int unsigned HOLD_OFF_CYCLES = 300;   // long output stall, fills the queue
  localparam int unsigned WATCHDOG_LIMIT  = 3000;  // cycles with no handshake at all
  localparam int unsigned MAX_PRINTS      = 200;

  // Op code the block must ignore, and the two unmapped config indexes.
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [1:0] CFG_UNMAPPED_B = 2'd3;

  // ---------------------------------------------------------------------------
  // Directed table layout
  // ---------------------------------------------------------------------------
  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  // Where the rx byte of a row comes from: the row itself, or the CRC of the
  // response bytes sent since the last start (optionally corrupted).
  typedef enum logic [1:0] {
    BYTE_AS_IS,
    BYTE_CRC_LO,
    BYTE_CRC_HI,
    BYTE_CRC_HI_BAD
  } byte_src_e;

  typedef struct packed {
    row_kind_e   kind;
    in_item_t    item;
    byte_src_e   src;
    logic        typed;     // want holds the single expected item
    out_item_t   want;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  modbus_rtu_read_register_master i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // ---------------------------------------------------------------------------
  // Predictor state: config copy plus the response gatherer
  // ---------------------------------------------------------------------------
  logic [7:0]  dev_addr_q    = DEVICE_ADDRESS_RST;
  logic [15:0] timeout_q     = TIMEOUT_TICKS_RST;
  logic        link_busy     = 1'b0;     // request sent, response pending
  logic [2:0]  resp_count    = 3'd0;
  logic [15:0] resp_crc      = CRC_INIT;
  logic [15:0] resp_value    = 16'h0000;
  logic [7:0]  resp_crc_lo   = 8'h00;
  logic [15:0] tick_count_q  = 16'h0000;

  out_item_t   pending_results [$];      // expected output items, oldest first
  int unsigned useful_items  = 0;        // items that were not simply ignored
  int unsigned results_seen  = 0;
  int unsigned error_count   = 0;

  // Idling controls, set by the stimulus; the last two steer the receiver.
  bit          tx_gaps       = 1'b0;
  bit          rx_stalls     = 1'b0;
  bit          hold_off_req  = 1'b0;

  stim_row_t   directed_rows [DIR_ROWS];
  out_item_t   oldest_want;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC-16/MODBUS, reflected, one bit at a time from the LSB.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic out_item_t make_reading(input logic [15:0] v, input status_e s);
    out_item_t r;
    r            = '0;
    r.is_reading = CMD_READING;
    r.value      = v;
    r.status     = s;
    return r;
  endfunction

  // Applies one accepted item to the predictor, queues the output items it
  // causes, and tells whether the item touched the block's state at all.
  function automatic bit predict_master(input in_item_t it);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    logic [16:0] tick_next;
    out_item_t   tx;
    bit          absorbed;
    absorbed = 1'b0;
    case (it.operation)
      OP_START: begin
        frame[0] = dev_addr_q;
        frame[1] = FUNC_READ_HOLDING;
        frame[2] = 8'h00;
        frame[3] = it.register_address;
        frame[4] = 8'h00;
        frame[5] = QUANTITY_ONE;
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++) crc = crc16_step(crc, frame[k]);
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        for (int k = 0; k < 8; k++) begin
          tx            = '0;
          tx.is_reading = CMD_REQUEST;
          tx.tx_byte    = frame[k];
          tx.last       = (k == 7);
          pending_results.push_back(tx);
        end
        // a start abandons whatever exchange was open
        link_busy    = 1'b1;
        resp_count   = 3'd0;
        resp_crc     = CRC_INIT;
        resp_value   = 16'h0000;
        resp_crc_lo  = 8'h00;
        tick_count_q = 16'h0000;
        absorbed     = 1'b1;
      end
      OP_RX: begin
        if (link_busy) begin
          absorbed = 1'b1;
          if (resp_count < RX_CRC_LO) begin
            resp_crc = crc16_step(resp_crc, it.rx_byte);
            if (resp_count == RX_VALUE_HI) resp_value[15:8] = it.rx_byte;
            if (resp_count == RX_VALUE_LO) resp_value[7:0]  = it.rx_byte;
            resp_count = resp_count + 3'd1;
          end else if (resp_count == RX_CRC_LO) begin
            resp_crc_lo = it.rx_byte;
            resp_count  = RX_CRC_HI;
          end else begin
            pending_results.push_back(make_reading(resp_value,
                ({it.rx_byte, resp_crc_lo} == resp_crc) ? ST_OK : ST_CRC_ERR));
            link_busy  = 1'b0;
            resp_count = 3'd0;
          end
        end
      end
      OP_TICK: begin
        if (link_busy) begin
          absorbed  = 1'b1;
          tick_next = {1'b0, tick_count_q} + 17'd1;
          // compare against the limit as it stands now, so a lowered limit
          // fires on the next tick
          if (tick_next >= {1'b0, timeout_q}) begin
            pending_results.push_back(make_reading(16'h0000, ST_TIMEOUT));
            link_busy  = 1'b0;
            resp_count = 3'd0;
          end
          tick_count_q = tick_next[15:0];
        end
      end
      default: ;
    endcase
    return absorbed;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoring
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    // keep the log bounded if the block goes badly wrong
    if (error_count <= MAX_PRINTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("item %0d field %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Output monitor: every accepted item is held against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("item %0d arrived with nothing expected", results_seen));
      end else begin
        oldest_want = pending_results.pop_front();
        check_field("is_reading", 16'(out_item_o.is_reading), 16'(oldest_want.is_reading));
        check_field("tx_byte", 16'(out_item_o.tx_byte), 16'(oldest_want.tx_byte));
        check_field("last", 16'(out_item_o.last), 16'(oldest_want.last));
        check_field("value", out_item_o.value, oldest_want.value);
        check_field("status", 16'(out_item_o.status), 16'(oldest_want.status));
      end
      results_seen++;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request.
  // Drives out_ready_i once per falling edge.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left   = 0;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (rx_stalls && hold_left == 0 && stall_left == 0 &&
                   $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_item(input logic [1:0] op, input logic [7:0] reg_a,
                                       input logic [7:0] b);
    in_item_t it;
    it.operation        = op;
    it.register_address = reg_a;
    it.rx_byte          = b;
    return it;
  endfunction

  function automatic stim_row_t in_row(input logic [1:0] op, input logic [7:0] reg_a,
                                       input logic [7:0] b, input byte_src_e src);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.item = mk_item(op, reg_a, b);
    r.src  = src;
    return r;
  endfunction

  function automatic stim_row_t chk_row(input logic [1:0] op, input logic [7:0] reg_a,
                                        input logic [7:0] b, input byte_src_e src,
                                        input out_item_t want);
    stim_row_t r;
    r       = in_row(op, reg_a, b, src);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [15:0] data);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_CFG;
    r.cfg_index = idx;
    r.cfg_data  = data;
    return r;
  endfunction

  // Offers one item (after an optional gap) and holds it until accepted.
  task automatic send_item(input in_item_t it, output bit absorbed);
    int unsigned gap;
    gap = 0;
    if (tx_gaps && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    absorbed = predict_master(it);
    if (absorbed) useful_items++;
  endtask

  task automatic send_ticks(input int unsigned n);
    bit absorbed;
    repeat (n) send_item(mk_item(OP_TICK, 8'($urandom), 8'($urandom)), absorbed);
  endtask

  // Ticks enough to reach a small limit; a handful when the limit is large.
  function automatic int unsigned ticks_to_expire();
    return (timeout_q <= 40) ? int'(timeout_q) + 1 : $urandom_range(1, 5);
  endfunction

  // Drops the input valid, waits for every expected item, then lets the block
  // finish any byte or tick still in flight.
  task automatic wait_for_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DEVICE_ADDRESS: dev_addr_q = data[7:0];
      CFG_TIMEOUT_TICKS:  timeout_q  = data;
      default: ;  // unmapped index, ignored
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One request/response exchange: start, then the 7-byte response with a
  // correct CRC most of the time. Ticks may fall between bytes; some replies
  // carry a flipped CRC bit, and some are cut short and followed by ticks.
  task automatic run_exchange();
    logic [7:0]  reply [7];
    logic [15:0] crc;
    int unsigned cut;
    bit          absorbed;
    send_item(mk_item(OP_START, 8'($urandom), 8'($urandom)), absorbed);
    reply[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : dev_addr_q;
    reply[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : FUNC_READ_HOLDING;
    reply[2] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h02;
    reply[3] = 8'($urandom);
    reply[4] = 8'($urandom);
    crc = CRC_INIT;
    for (int k = 0; k < 5; k++) crc = crc16_step(crc, reply[k]);
    reply[5] = crc[7:0];
    reply[6] = crc[15:8];
    if ($urandom_range(0, 6) == 0) begin
      reply[5 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 7;
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(0, 4) == 0) send_ticks($urandom_range(1, 3));
      send_item(mk_item(OP_RX, 8'($urandom), reply[k]), absorbed);
    end
    if (cut < 7) send_ticks(ticks_to_expire());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   row;
    in_item_t    item;
    bit          absorbed;
    logic [15:0] reply_crc;
    int unsigned reply_n;
    int unsigned target;
    int unsigned pick;
    logic [7:0]  dev;
    logic [15:0] tmo;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    reply_crc   = CRC_INIT;
    reply_n     = 0;

    // Directed table. Typed expectations only where the answer is obvious;
    // request frames are always scored by the predictor.
    directed_rows = '{
      // reset config: slave 0x12; read back 0xFFFF with a good CRC
      in_row(OP_START, 8'h00, 8'h00, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h12, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h03, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h02, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'hFF, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'hFF, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h00, BYTE_CRC_LO),
      chk_row(OP_RX, 8'h00, 8'h00, BYTE_CRC_HI, make_reading(16'hFFFF, ST_OK)),
      // idle: stray byte, stray tick and the unused op code do nothing
      in_row(OP_RX, 8'hFF, 8'hAA, BYTE_AS_IS),
      in_row(OP_TICK, 8'hFF, 8'hFF, BYTE_AS_IS),
      in_row(OP_UNUSED, 8'hFF, 8'hFF, BYTE_AS_IS),
      // top slave address, zero timeout, writes to unmapped indexes
      cfg_row(CFG_DEVICE_ADDRESS, 16'h00FF),
      cfg_row(CFG_TIMEOUT_TICKS, 16'h0000),
      cfg_row(CFG_UNMAPPED_A, 16'hFFFF),
      cfg_row(CFG_UNMAPPED_B, 16'hFFFF),
      // zero timeout fires on the first tick
      in_row(OP_START, 8'hFF, 8'h00, BYTE_AS_IS),
      chk_row(OP_TICK, 8'h00, 8'h00, BYTE_AS_IS, make_reading(16'h0000, ST_TIMEOUT)),
      cfg_row(CFG_DEVICE_ADDRESS, 16'h0000),
      cfg_row(CFG_TIMEOUT_TICKS, 16'd3),
      // start while waiting abandons the open exchange silently
      in_row(OP_START, 8'h5A, 8'h00, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h00, BYTE_AS_IS),
      in_row(OP_START, 8'hA5, 8'hFF, BYTE_AS_IS),
      in_row(OP_TICK, 8'h00, 8'h00, BYTE_AS_IS),
      in_row(OP_TICK, 8'h00, 8'h00, BYTE_AS_IS),
      // limit lowered under a running count: next tick fires
      cfg_row(CFG_TIMEOUT_TICKS, 16'd1),
      chk_row(OP_TICK, 8'h00, 8'h00, BYTE_AS_IS, make_reading(16'h0000, ST_TIMEOUT)),
      cfg_row(CFG_TIMEOUT_TICKS, 16'hFFFF),
      // bad CRC high byte: value still reported, status CRC error
      in_row(OP_START, 8'h80, 8'h00, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h00, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h03, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h02, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h80, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h01, BYTE_AS_IS),
      in_row(OP_RX, 8'h00, 8'h00, BYTE_CRC_LO),
      chk_row(OP_RX, 8'h00, 8'h00, BYTE_CRC_HI_BAD, make_reading(16'h8001, ST_CRC_ERR))
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        wait_for_quiet();
        write_cfg(row.cfg_index, row.cfg_data);
      end else begin
        item = row.item;
        case (row.src)
          BYTE_CRC_LO:     item.rx_byte = reply_crc[7:0];
          BYTE_CRC_HI:     item.rx_byte = reply_crc[15:8];
          BYTE_CRC_HI_BAD: item.rx_byte = ~reply_crc[15:8];
          default: ;
        endcase
        // running CRC of the response bytes, so table rows can refer to it
        if (item.operation == OP_START) begin
          reply_crc = CRC_INIT;
          reply_n   = 0;
        end else if (item.operation == OP_RX && row.src == BYTE_AS_IS && reply_n < 5) begin
          reply_crc = crc16_step(reply_crc, item.rx_byte);
          reply_n++;
        end
        send_item(item, absorbed);
        if (row.typed) pending_results[pending_results.size() - 1] = row.want;
      end
    end

    // ---- random part, in phases with a fresh config each ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_quiet();
      // last phase runs flat out on both sides
      tx_gaps   = (ph != NUM_PHASES - 1);
      rx_stalls = (ph != NUM_PHASES - 1);
      case (ph)
        0: begin
          dev = 8'($urandom);
          tmo = 16'($urandom_range(2, 30));
        end
        1: begin
          dev = 8'hFF;
          tmo = 16'hFFFF;
        end
        2: begin
          dev = 8'h00;
          tmo = 16'd1;
        end
        3: begin
          dev = 8'($urandom);
          tmo = 16'($urandom_range(0, 12));
        end
        default: begin
          dev = 8'($urandom);
          tmo = 16'($urandom_range(3, 40));
        end
      endcase
      write_cfg(CFG_TIMEOUT_TICKS, tmo);
      if ($urandom_range(0, 1) == 0) write_cfg(2'($urandom_range(2, 3)), 16'($urandom));
      write_cfg(CFG_DEVICE_ADDRESS, {8'($urandom), dev});

      if (ph == 0) begin
        // Back-pressure: the receiver holds off for a long stretch while
        // starts keep coming, so the command queue fills and the input stalls.
        tx_gaps      = 1'b0;
        hold_off_req = 1'b1;
        repeat (6) send_item(mk_item(OP_START, 8'($urandom), 8'($urandom)), absorbed);
        tx_gaps      = 1'b1;
      end

      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          run_exchange();
        end else if (pick < 80) begin
          // request followed only by ticks
          send_item(mk_item(OP_START, 8'($urandom), 8'($urandom)), absorbed);
          send_ticks(ticks_to_expire());
        end else if (pick < 92) begin
          // noise: any op code, any payload
          send_item(mk_item(2'($urandom), 8'($urandom), 8'($urandom)), absorbed);
        end else begin
          // broken exchange: a few bytes, then whatever comes next
          send_item(mk_item(OP_START, 8'($urandom), 8'($urandom)), absorbed);
          repeat ($urandom_range(0, 4)) begin
            send_item(mk_item(OP_RX, 8'($urandom), 8'($urandom)), absorbed);
          end
        end
      end
    end

    // ---- drain and verdict ----
    wait_for_quiet();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
